### src/rtwa_pkg.sv
// shared constants and types for the routing table with aging
package rtwa_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BYTES  = 2;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // addresses wrap at the configured byte count, capped by the 16-bit ports
    localparam logic [15:0] ADDR_MASK = (8 * ADDR_BYTES >= 16) ? 16'hFFFF :
                                        16'((32'd1 << (8 * ADDR_BYTES)) - 32'd1);

    localparam logic [1:0] MODE_LEARN = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_ROUTE = 2'd2;
    localparam logic [1:0] MODE_CHECK = 2'd3;

    localparam logic [2:0] STS_ADDED   = 3'd0;
    localparam logic [2:0] STS_UPDATED = 3'd1;
    localparam logic [2:0] STS_FULL    = 3'd2;
    localparam logic [2:0] STS_UNICAST = 3'd3;
    localparam logic [2:0] STS_CHILD   = 3'd4;
    localparam logic [2:0] STS_NOROUTE = 3'd5;
    localparam logic [2:0] STS_CHECK   = 3'd6;
    localparam logic [2:0] STS_SWEPT   = 3'd7;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] hop;
        logic [31:0] stamp;
        logic [7:0]  role;
    } entry_t;

endpackage

### src/routing_table_with_aging.sv
// routing table with aging: learn, expire sweep, route lookup and child check
// Entries sit in one synchronous RAM with a single read and a single write port; live
// entries always fill slots 0 .. count-1, so no clearing pass is needed after reset.
// One word is taken at a time. Learn, route and child check scan one entry per cycle
// and stop at the first hit; a child listing (route to address 0) scans every entry
// and holds while a child copy waits on a stalled output. In an expire sweep a removal
// reads the last entry in the same cycle and the moved entry is checked in the next one.
module routing_table_with_aging (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] now,
    input  logic [15:0] dest_addr,
    input  logic [15:0] hop_addr,
    input  logic [7:0]  node_role,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [15:0] target_addr,
    output logic        found,
    output logic [4:0]  removed_count,
    output logic [4:0]  table_size,
    output logic        last
);
    import rtwa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      timeout_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             move_reg, move_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [15:0]      pend_addr_reg, pend_addr_next;

    logic [1:0]       mode_reg;
    logic [31:0]      now_reg;
    logic [15:0]      dest_reg, hop_reg;
    logic [7:0]       role_reg;

    logic [2:0]       fin_status_reg, fin_status_next;
    logic [15:0]      fin_target_reg, fin_target_next;
    logic             fin_found_reg, fin_found_next;
    logic             fin_wr_reg, fin_wr_next;
    logic             fin_add_reg, fin_add_next;
    logic [IDX_W-1:0] fin_idx_reg, fin_idx_next;

    logic             out_valid_reg;
    logic [2:0]       out_status_reg;
    logic [15:0]      out_target_reg;
    logic             out_found_reg;
    logic [4:0]       out_removed_reg;
    logic [4:0]       out_size_reg;
    logic             out_last_reg;

    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             emit;
    logic [2:0]       emit_status;
    logic [15:0]      emit_target;
    logic             emit_found;
    logic [CNT_W-1:0] emit_removed;
    logic [CNT_W-1:0] emit_size;
    logic             emit_last;

    logic             can_emit;
    logic             take;
    logic             at_end;
    logic             is_child;
    logic             expired;
    logic [31:0]      age;
    logic [15:0]      dest_in;
    logic [15:0]      hop_in;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE);
    assign take       = item_valid && !item_stall;
    assign can_emit   = !out_valid_reg || !result_stall;
    assign dest_in    = dest_addr & ADDR_MASK;
    assign hop_in     = hop_addr & ADDR_MASK;
    assign at_end     = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign is_child   = (rd_data_reg.dest == rd_data_reg.hop);
    assign age        = now_reg - rd_data_reg.stamp;
    assign expired    = (age > timeout_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        move_next       = move_reg;
        removed_next    = removed_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        fin_status_next = fin_status_reg;
        fin_target_next = fin_target_reg;
        fin_found_next  = fin_found_reg;
        fin_wr_next     = fin_wr_reg;
        fin_add_next    = fin_add_reg;
        fin_idx_next    = fin_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = IDX_W'(idx_reg + 1'b1);
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data_reg;
        emit            = 1'b0;
        emit_status     = STS_CHILD;
        emit_target     = pend_addr_reg;
        emit_found      = 1'b0;
        emit_removed    = '0;
        emit_size       = cnt_reg;
        emit_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    pend_valid_next = 1'b0;
                    removed_next    = '0;
                    idx_next        = '0;
                    move_next       = 1'b0;
                    rd_en           = 1'b1;
                    rd_addr         = '0;
                    fin_target_next = '0;
                    fin_found_next  = 1'b0;
                    fin_wr_next     = 1'b0;
                    fin_add_next    = 1'b0;
                    fin_idx_next    = IDX_W'(cnt_reg);
                    unique case (mode)
                        MODE_LEARN:
                        begin
                            if (cnt_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                fin_status_next = STS_FULL;
                                state_next      = S_DONE;
                            end
                            else if (cnt_reg == '0)
                            begin
                                fin_status_next = STS_ADDED;
                                fin_wr_next     = 1'b1;
                                fin_add_next    = 1'b1;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_SWEEP:
                        begin
                            fin_status_next = STS_SWEPT;
                            state_next      = (cnt_reg == '0) ? S_DONE : S_SWEEP;
                        end
                        MODE_ROUTE:
                        begin
                            fin_status_next = STS_NOROUTE;
                            state_next      = (cnt_reg == '0) ? S_DONE : S_SCAN;
                        end
                        MODE_CHECK:
                        begin
                            fin_status_next = STS_CHECK;
                            state_next      = (cnt_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                unique case (mode_reg)
                    MODE_LEARN:
                    begin
                        if (rd_data_reg.dest == dest_reg)
                        begin
                            fin_status_next = STS_UPDATED;
                            fin_wr_next     = 1'b1;
                            fin_idx_next    = idx_reg;
                            state_next      = S_DONE;
                        end
                        else if (at_end)
                        begin
                            fin_status_next = STS_ADDED;
                            fin_wr_next     = 1'b1;
                            fin_add_next    = 1'b1;
                            fin_idx_next    = IDX_W'(cnt_reg);
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = IDX_W'(idx_reg + 1'b1);
                        end
                    end
                    MODE_ROUTE:
                    begin
                        if (dest_reg != '0)
                        begin
                            if (rd_data_reg.dest == dest_reg)
                            begin
                                fin_status_next = STS_UNICAST;
                                fin_target_next = rd_data_reg.hop;
                                state_next      = S_DONE;
                            end
                            else if (at_end)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = IDX_W'(idx_reg + 1'b1);
                            end
                        end
                        // a child copy is held back one hit so the final one can carry last
                        else if (!(is_child && pend_valid_reg && !can_emit))
                        begin
                            if (is_child && pend_valid_reg)
                            begin
                                emit = 1'b1;
                            end
                            if (is_child)
                            begin
                                pend_valid_next = 1'b1;
                                pend_addr_next  = rd_data_reg.dest;
                            end
                            if (at_end)
                            begin
                                if (is_child || pend_valid_reg)
                                begin
                                    fin_status_next = STS_CHILD;
                                    fin_target_next = is_child ? rd_data_reg.dest
                                                               : pend_addr_reg;
                                end
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = IDX_W'(idx_reg + 1'b1);
                            end
                        end
                    end
                    MODE_CHECK:
                    begin
                        if (rd_data_reg.hop == hop_reg)
                        begin
                            fin_found_next = 1'b1;
                            state_next     = S_DONE;
                        end
                        else if (at_end)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = IDX_W'(idx_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SWEEP:
            begin
                // the last entry read on the previous removal lands in the freed slot
                wr_en = move_reg;
                if (expired && at_end)
                begin
                    cnt_next     = cnt_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                    state_next   = S_DONE;
                end
                else if (expired)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = IDX_W'(cnt_reg - CNT_W'(1));
                    cnt_next     = cnt_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                    move_next    = 1'b1;
                end
                else if (at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    idx_next  = IDX_W'(idx_reg + 1'b1);
                    move_next = 1'b0;
                end
            end

            S_DONE:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    emit_status  = fin_status_reg;
                    emit_target  = fin_target_reg;
                    emit_found   = fin_found_reg;
                    emit_removed = removed_reg;
                    emit_size    = fin_add_reg ? cnt_reg + CNT_W'(1) : cnt_reg;
                    emit_last    = 1'b1;
                    wr_en        = fin_wr_reg;
                    wr_addr      = fin_idx_reg;
                    wr_data      = '{dest: dest_reg, hop: hop_reg, stamp: now_reg,
                                     role: role_reg};
                    if (fin_add_reg)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            timeout_reg    <= 32'd65535;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        move_reg       <= move_next;
        removed_reg    <= removed_next;
        pend_addr_reg  <= pend_addr_next;
        fin_status_reg <= fin_status_next;
        fin_target_reg <= fin_target_next;
        fin_found_reg  <= fin_found_next;
        fin_wr_reg     <= fin_wr_next;
        fin_add_reg    <= fin_add_next;
        fin_idx_reg    <= fin_idx_next;
        if (take)
        begin
            mode_reg <= mode;
            now_reg  <= now;
            dest_reg <= dest_in;
            hop_reg  <= hop_in;
            role_reg <= node_role;
        end
        if (emit)
        begin
            out_status_reg  <= emit_status;
            out_target_reg  <= emit_target;
            out_found_reg   <= emit_found;
            out_removed_reg <= 5'(emit_removed);
            out_size_reg    <= 5'(emit_size);
            out_last_reg    <= emit_last;
        end
    end

    // table ram, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign target_addr   = out_target_reg;
    assign found         = out_found_reg;
    assign removed_count = out_removed_reg;
    assign table_size    = out_size_reg;
    assign last          = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_idx_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SWEEP) |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("scan index outside live entries");

    a_only_child_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg || out_status_reg == STS_CHILD))
        else $error("non-final word that is not a child copy");

    a_learn_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && fin_add_reg && can_emit)
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("added entry did not grow the table");

endmodule

### test/tb_routing_table_with_aging.sv
// testbench for the routing table with aging: learn, sweep, route and child check traffic
`timescale 1ns / 1ps

module tb_routing_table_with_aging;
    import rtwa_pkg::*;

    localparam int STUCK_LIMIT = 3000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] target;
        logic        found;
        logic [4:0]  removed;
        logic [4:0]  size;
        logic        last;
    } table_reply_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  mode = MODE_LEARN;
    logic [31:0] now = '0;
    logic [15:0] dest_addr = '0;
    logic [15:0] hop_addr = '0;
    logic [7:0]  node_role = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] target_addr;
    logic        found;
    logic [4:0]  removed_count;
    logic [4:0]  table_size;
    logic        last;

    // shadow copy of the table and its timeout
    entry_t       shadow_tbl [TABLE_DEPTH];
    int           shadow_count = 0;
    logic [31:0]  shadow_timeout = 32'd65535;
    table_reply_t table_replies_due [$];
    table_reply_t want_reply;

    int error_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    routing_table_with_aging uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .now           (now),
        .dest_addr     (dest_addr),
        .hop_addr      (hop_addr),
        .node_role     (node_role),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .target_addr   (target_addr),
        .found         (found),
        .removed_count (removed_count),
        .table_size    (table_size),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("%s: want %0h got %0h", field, want, got));
    endtask

    function automatic table_reply_t make_reply(input logic [2:0] st, input logic [15:0] tgt,
                                                input logic hit, input logic [4:0] gone,
                                                input logic fin);
        table_reply_t r;
        r.status  = st;
        r.target  = tgt;
        r.found   = hit;
        r.removed = gone;
        r.size    = 5'(shadow_count);
        r.last    = fin;
        return r;
    endfunction

    // updates the shadow table for one word and queues the replies it should give
    task automatic apply_table_op(input logic [1:0] op, input logic [31:0] tick,
                                  input logic [15:0] dst_in, input logic [15:0] nh_in,
                                  input logic [7:0] role);
        logic [15:0]  dst;
        logic [15:0]  nh;
        logic [31:0]  age;
        int           slot;
        int           gone;
        logic         hit;
        table_reply_t kids [$];
        dst  = dst_in & ADDR_MASK;
        nh   = nh_in & ADDR_MASK;
        slot = -1;
        gone = 0;
        hit  = 1'b0;
        case (op)
            MODE_LEARN:
            begin
                // a full table drops every learn, refreshes included
                if (shadow_count == TABLE_DEPTH)
                    table_replies_due.push_back(make_reply(STS_FULL, '0, 1'b0, '0, 1'b1));
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                        if (slot < 0 && shadow_tbl[i].dest == dst)
                            slot = i;
                    if (slot >= 0)
                    begin
                        shadow_tbl[slot] = '{dest: dst, hop: nh, stamp: tick, role: role};
                        table_replies_due.push_back(
                            make_reply(STS_UPDATED, '0, 1'b0, '0, 1'b1));
                    end
                    else
                    begin
                        shadow_tbl[shadow_count] = '{dest: dst, hop: nh, stamp: tick,
                                                     role: role};
                        shadow_count++;
                        table_replies_due.push_back(make_reply(STS_ADDED, '0, 1'b0, '0, 1'b1));
                    end
                end
            end
            MODE_SWEEP:
            begin
                // expired slot takes the last entry and is looked at again
                slot = 0;
                while (slot < shadow_count)
                begin
                    age = tick - shadow_tbl[slot].stamp;
                    if (age > shadow_timeout)
                    begin
                        shadow_tbl[slot] = shadow_tbl[shadow_count - 1];
                        shadow_count--;
                        gone++;
                    end
                    else
                        slot++;
                end
                table_replies_due.push_back(make_reply(STS_SWEPT, '0, 1'b0, 5'(gone), 1'b1));
            end
            MODE_ROUTE:
            begin
                if (dst == '0)
                begin
                    // direct children are entries whose next hop is the destination itself
                    for (int i = 0; i < shadow_count; i++)
                        if (shadow_tbl[i].dest == shadow_tbl[i].hop)
                            kids.push_back(make_reply(STS_CHILD, shadow_tbl[i].dest, 1'b0,
                                                      '0, 1'b0));
                    if (kids.size() == 0)
                        table_replies_due.push_back(
                            make_reply(STS_NOROUTE, '0, 1'b0, '0, 1'b1));
                    else
                    begin
                        kids[kids.size() - 1].last = 1'b1;
                        foreach (kids[k])
                            table_replies_due.push_back(kids[k]);
                    end
                end
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                        if (slot < 0 && shadow_tbl[i].dest == dst)
                            slot = i;
                    if (slot >= 0)
                        table_replies_due.push_back(
                            make_reply(STS_UNICAST, shadow_tbl[slot].hop, 1'b0, '0, 1'b1));
                    else
                        table_replies_due.push_back(
                            make_reply(STS_NOROUTE, '0, 1'b0, '0, 1'b1));
                end
            end
            default:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_tbl[i].hop == nh)
                        hit = 1'b1;
                table_replies_due.push_back(make_reply(STS_CHECK, '0, hit, '0, 1'b1));
            end
        endcase
    endtask

    // observes every handshake: predicts, checks replies and watches for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (item_valid && !item_stall) ||
                (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (cfg_valid && cfg_ready)
                shadow_timeout = cfg_data;
            if (item_valid && !item_stall)
                apply_table_op(mode, now, dest_addr, hop_addr, node_role);
            if (result_valid && !result_stall)
            begin
                if (table_replies_due.size() == 0)
                    flag_error($sformatf("unexpected reply, status %0d", status));
                else
                begin
                    want_reply = table_replies_due.pop_front();
                    check_field("status", 32'(want_reply.status), 32'(status));
                    check_field("target_addr", 32'(want_reply.target), 32'(target_addr));
                    check_field("found", 32'(want_reply.found), 32'(found));
                    check_field("removed_count", 32'(want_reply.removed),
                                32'(removed_count));
                    check_field("table_size", 32'(want_reply.size), 32'(table_size));
                    check_field("last", 32'(want_reply.last), 32'(last));
                end
            end
            if (idle_cycles >= STUCK_LIMIT)
            begin
                $display("tb_routing_table_with_aging: errors");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] tick,
                             input logic [15:0] dst, input logic [15:0] nh,
                             input logic [7:0] role);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        mode       <= op;
        now        <= tick;
        dest_addr  <= dst;
        hop_addr   <= nh;
        node_role  <= role;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic wait_table_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (table_replies_due.size() != 0);
    endtask

    task automatic set_timeout(input logic [31:0] ticks);
        wait_table_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_item(MODE_ROUTE, 32'd0, 16'h1234, 16'h0000, 8'h00);
        send_item(MODE_ROUTE, 32'd0, 16'h0000, 16'h0000, 8'h00);
        send_item(MODE_CHECK, 32'd0, 16'h0000, 16'hFFFF, 8'h00);
        send_item(MODE_SWEEP, 32'd0, 16'h0000, 16'h0000, 8'h00);
    endtask

    // stamps straddle the wrap of the tick counter
    task automatic test_fill_and_full();
        logic [15:0] dst;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            dst = 16'(i * 16'h1111);
            send_item(MODE_LEARN, 32'hFFFF_FFF8 + 32'(i), dst,
                      (i % 2 == 0) ? dst : dst ^ 16'hA5A5, 8'(i * 17));
        end
        send_item(MODE_LEARN, 32'd9, 16'h1111, 16'h1111, 8'h01);
        send_item(MODE_LEARN, 32'd9, 16'h1234, 16'h4321, 8'h02);
        send_item(MODE_ROUTE, 32'd9, 16'h0000, 16'h0000, 8'h00);
        send_item(MODE_ROUTE, 32'd9, 16'hFFFF, 16'h0000, 8'h00);
        send_item(MODE_CHECK, 32'd9, 16'h0000, 16'h5A5A, 8'h00);
    endtask

    // age equal to the timeout survives, one more tick expires
    task automatic test_expiry_wrap();
        set_timeout(32'd3);
        send_item(MODE_SWEEP, 32'd10, 16'h0000, 16'h0000, 8'h00);
        send_item(MODE_ROUTE, 32'd10, 16'hFFFF, 16'h0000, 8'h00);
        send_item(MODE_LEARN, 32'd10, 16'hFFFF, 16'hFFFF, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_in, input int stall_out,
                                       input logic [31:0] ticks, input int tick_step);
        logic [15:0] pool [20];
        logic [31:0] tick;
        logic [15:0] dst;
        logic [15:0] nh;
        int          pick;
        set_timeout(ticks);
        send_idle_pct  = idle_in;
        recv_stall_pct = stall_out;
        foreach (pool[k])
            pool[k] = 16'($urandom);
        tick = $urandom;
        repeat (n_items)
        begin
            tick += 32'($urandom_range(0, tick_step));
            dst  = pool[$urandom_range(0, 19)];
            nh   = ($urandom_range(0, 2) == 0) ? dst : pool[$urandom_range(0, 19)];
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(2'($urandom), $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
            else if (pick < 50)
                send_item(MODE_LEARN, tick, dst, nh, 8'($urandom));
            else if (pick < 60)
                send_item(MODE_SWEEP, tick, 16'($urandom), 16'($urandom), 8'($urandom));
            else if (pick < 70)
                send_item(MODE_ROUTE, tick, 16'h0000, nh, 8'($urandom));
            else if (pick < 85)
                send_item(MODE_ROUTE, tick, dst, nh, 8'($urandom));
            else
                send_item(MODE_CHECK, tick, dst, nh, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_fill_and_full();
        test_expiry_wrap();
        test_random_traffic(25, 0, 0, 32'hFFFF_FFFF, 1000000);
        test_random_traffic(25, 83, 0, 32'h0000_0000, 1);
        test_random_traffic(25, 0, 83, 32'd50, 20);
        test_random_traffic(25, 24, 24, 32'd200, 60);
        wait_table_idle();
        repeat (40) @(posedge clk);
        if (table_replies_due.size() != 0)
            flag_error($sformatf("%0d replies never arrived", table_replies_due.size()));
        if (error_count == 0)
            $display("tb_routing_table_with_aging: clean");
        else
            $display("tb_routing_table_with_aging: errors");
        $finish;
    end

endmodule

### routing_table_with_aging.f
src/rtwa_pkg.sv
src/routing_table_with_aging.sv
test/tb_routing_table_with_aging.sv
